// ===== sv/tdle_pkg.sv =====
// Shared types and constants of the tree distance / common ancestor engine.
// Holds the command and status structs between controller and datapath; no dependencies.
package tdle_pkg;

	// Field widths
	localparam int IN_NODE_W = 16;
	localparam int LEN_W     = 30;
	localparam int DIST_W    = 47;
	localparam int DEPTH_W   = 16;

	// Index reduction runs three steps: quotient estimate, remainder, correction
	localparam int RED_CNT_W = 2;

	// Defaults for the top-level parameters
	localparam int MAX_NODES_DEF  = 65536;
	localparam int LOG_LEVELS_DEF = 16;

	// Item kinds
	localparam logic KIND_ATTACH = 1'b0;
	localparam logic KIND_QUERY  = 1'b1;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;        // capture an accepted item
		logic red_step;    // one step of the node index reduction
		logic dd_sel_c;    // depth/distance port A addresses the current node
		logic wr_node;     // write depth, distance and first ancestor of new node
		logic wr_lvl;      // write next ancestor level of new node
		logic swap;        // order query nodes by depth, form depth difference
		logic p_from_tbl;  // load current node from ancestor read port A
		logic diff_shift;  // drop lowest bit of depth difference
		logic lvl_clr;     // level counter to zero
		logic lvl_top;     // level counter to highest level
		logic lvl_inc;
		logic lvl_dec;
		logic jump;        // lift both nodes where their ancestors differ
		logic sum;         // form distance sum and twice ancestor distance
		logic out_load;    // load result register
	} ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic red_last;
		logic is_query;
		logic attach_skip;
		logic single_lvl;
		logic lvl_nx_last;
		logic lvl_at_top;
		logic lvl_zero;
		logic diff_bit;
		logic p_eq_q;
	} sts_t;

endpackage

// ===== sv/tree_distance_lca_engine_unit.sv =====
// Tree distance / lowest common ancestor engine, one item at a time: index reduction, then
// attach (ancestor table fill, skipped if the item is ignored) or query (depth climb, then
// joint climb, skipped when the depth climb meets), with one ancestor memory read per level
// step; the next item is taken after that. A result waits in its own register. Reset clears
// only control state; root entries read as zero by address decode, so no clearing pass runs.
// Other entries are undefined until written.
module tree_distance_lca_engine_unit
	import tdle_pkg::*;
#(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int LOG_LEVELS = LOG_LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 kind,
	input  logic [IN_NODE_W-1:0] node_a,
	input  logic [IN_NODE_W-1:0] node_b,
	input  logic [LEN_W-1:0]     edge_length,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DIST_W-1:0]    distance,
	output logic [IN_NODE_W-1:0] common_ancestor
);

	ctl_t ctl;
	sts_t sts;

	// Sequencer
	tdle_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.ctl       (ctl),
		.sts       (sts)
	);

	// Memories and walk registers
	tdle_dp #(
		.MAX_NODES  (MAX_NODES),
		.LOG_LEVELS (LOG_LEVELS)
	) u_dp (
		.clk             (clk),
		.kind            (kind),
		.node_a          (node_a),
		.node_b          (node_b),
		.edge_length     (edge_length),
		.distance        (distance),
		.common_ancestor (common_ancestor),
		.ctl             (ctl),
		.sts             (sts)
	);

endmodule

// ===== sv/tdle_ctrl.sv =====
// Sequencer of the tree distance / common ancestor engine.
// Depends on tdle_pkg for the command and status structs.
module tdle_ctrl
	import tdle_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	output ctl_t ctl,
	input  sts_t sts
);

	typedef enum logic [16:0] {
		S_IDLE  = 17'h00001,
		S_RED   = 17'h00002,
		S_DEC   = 17'h00004,
		S_AWR0  = 17'h00008,
		S_ARD   = 17'h00010,
		S_AWR   = 17'h00020,
		S_QSWAP = 17'h00040,
		S_QUP   = 17'h00080,
		S_QUPW  = 17'h00100,
		S_QCHK  = 17'h00200,
		S_QJR   = 17'h00400,
		S_QJW   = 17'h00800,
		S_QPAR  = 17'h01000,
		S_QPARW = 17'h02000,
		S_QDC   = 17'h04000,
		S_QSUM  = 17'h08000,
		S_QFIN  = 17'h10000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// Next state and commands
	always_comb begin
		state_d = state_q;
		ctl     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					ctl.load = 1'b1;
					state_d  = S_RED;
				end
			end
			S_RED: begin
				ctl.red_step = 1'b1;
				if (sts.red_last) state_d = S_DEC;
			end
			S_DEC: begin
				if (sts.is_query) state_d = S_QSWAP;
				else if (sts.attach_skip) state_d = S_IDLE;
				else state_d = S_AWR0;
			end
			S_AWR0: begin
				ctl.wr_node = 1'b1;
				state_d = sts.single_lvl ? S_IDLE : S_ARD;
			end
			S_ARD: begin
				state_d = S_AWR;
			end
			S_AWR: begin
				ctl.wr_lvl     = 1'b1;
				ctl.p_from_tbl = 1'b1;
				ctl.lvl_inc    = 1'b1;
				state_d = sts.lvl_nx_last ? S_IDLE : S_ARD;
			end
			S_QSWAP: begin
				ctl.swap    = 1'b1;
				ctl.lvl_clr = 1'b1;
				state_d     = S_QUP;
			end
			S_QUP: begin
				// a set bit issues the ancestor read now and lifts next cycle
				if (sts.diff_bit) begin
					state_d = S_QUPW;
				end else begin
					ctl.diff_shift = 1'b1;
					ctl.lvl_inc    = 1'b1;
					if (sts.lvl_at_top) state_d = S_QCHK;
				end
			end
			S_QUPW: begin
				ctl.p_from_tbl = 1'b1;
				ctl.diff_shift = 1'b1;
				ctl.lvl_inc    = 1'b1;
				state_d = sts.lvl_at_top ? S_QCHK : S_QUP;
			end
			S_QCHK: begin
				if (sts.p_eq_q) begin
					state_d = S_QDC;
				end else begin
					ctl.lvl_top = 1'b1;
					state_d     = S_QJR;
				end
			end
			S_QJR: begin
				state_d = S_QJW;
			end
			S_QJW: begin
				ctl.jump = 1'b1;
				if (sts.lvl_zero) begin
					state_d = S_QPAR;
				end else begin
					ctl.lvl_dec = 1'b1;
					state_d     = S_QJR;
				end
			end
			S_QPAR: begin
				state_d = S_QPARW;
			end
			S_QPARW: begin
				ctl.p_from_tbl = 1'b1;
				state_d        = S_QDC;
			end
			S_QDC: begin
				ctl.dd_sel_c = 1'b1;
				state_d      = S_QSUM;
			end
			S_QSUM: begin
				ctl.sum = 1'b1;
				state_d = S_QFIN;
			end
			S_QFIN: begin
				// hold until the result register is free
				if (out_free) begin
					ctl.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== sv/tdle_dp.sv =====
// Datapath of the tree distance / common ancestor engine: ancestor, depth and
// distance memories, node registers, level counter and result register. Uses tdle_pkg.
module tdle_dp
	import tdle_pkg::*;
#(
	parameter int MAX_NODES  = MAX_NODES_DEF,
	parameter int LOG_LEVELS = LOG_LEVELS_DEF
) (
	input  logic                 clk,
	input  logic                 kind,
	input  logic [IN_NODE_W-1:0] node_a,
	input  logic [IN_NODE_W-1:0] node_b,
	input  logic [LEN_W-1:0]     edge_length,
	output logic [DIST_W-1:0]    distance,
	output logic [IN_NODE_W-1:0] common_ancestor,
	input  ctl_t                 ctl,
	output sts_t                 sts
);

	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int LVL_W  = (LOG_LEVELS > 1) ? $clog2(LOG_LEVELS) : 1;
	localparam logic [NODE_W:0]  MOD_C   = (NODE_W + 1)'(MAX_NODES);
	localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LOG_LEVELS - 1);
	localparam logic [LVL_W:0]   LVL_MAX_X = (LVL_W + 1)'(LOG_LEVELS - 1);
	localparam logic [DIST_W-1:0] DIST_SAT = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_SAT = '1;

	// Reciprocal of the node count; the quotient it gives is exact or one short
	localparam logic [31:0] RECIP  = 32'((64'd1 << 32) / MAX_NODES);
	localparam int          PROD_W = IN_NODE_W + 32;
	localparam int          QN_W   = IN_NODE_W + NODE_W + 1;

	// Index reduction steps
	localparam logic [RED_CNT_W-1:0] RED_QUOT = RED_CNT_W'(0);
	localparam logic [RED_CNT_W-1:0] RED_REM  = RED_CNT_W'(1);
	localparam logic [RED_CNT_W-1:0] RED_FIX  = RED_CNT_W'(2);

	// Memories
	logic [NODE_W-1:0]  anc_mem [MAX_NODES][LOG_LEVELS];
	logic [DEPTH_W-1:0] dep_mem [MAX_NODES];
	logic [DIST_W-1:0]  dst_mem [MAX_NODES];

	// Item and walk registers
	logic                 kind_q;
	logic [LEN_W-1:0]     len_q;
	logic [IN_NODE_W-1:0] sa_q, sb_q;
	logic [IN_NODE_W-1:0] qa_q, qb_q;
	logic [NODE_W:0]      rem_a_q, rem_b_q;
	logic [NODE_W-1:0]    ra_q, rb_q;
	logic [RED_CNT_W-1:0] red_cnt_q;
	logic [NODE_W-1:0]    p_q, q_q;
	logic [LVL_W-1:0]     lvl_q;
	logic [DEPTH_W-1:0]   diff_q;
	logic [DIST_W-1:0]    da_q, db_q;
	logic [DIST_W:0]      s_q, t_q;
	logic [DIST_W-1:0]    dist_q;
	logic [NODE_W-1:0]    ca_q;

	// Registered read data and root flags
	logic [NODE_W-1:0]  anc_rd_a_q, anc_rd_b_q;
	logic               anc_root_a_q, anc_root_b_q;
	logic [DEPTH_W-1:0] dep_rd_a_q, dep_rd_b_q;
	logic [DIST_W-1:0]  dst_rd_a_q, dst_rd_b_q;
	logic               dd_root_a_q, dd_root_b_q;

	logic [NODE_W-1:0]  tbl_a, tbl_b;
	logic [DEPTH_W-1:0] dep_a, dep_b;
	logic [DIST_W-1:0]  dst_a, dst_b;
	logic [NODE_W-1:0]  dd_addr_a;
	logic [LVL_W-1:0]   wr_lvl;
	logic [NODE_W-1:0]  wr_anc;
	logic               anc_we;
	logic [PROD_W-1:0]  prod_a, prod_b;
	logic [QN_W-1:0]    qn_a, qn_b, dif_a, dif_b;
	logic [NODE_W-1:0]  ra_d, rb_d;
	logic [DEPTH_W-1:0] dep_new;
	logic [DIST_W:0]    dst_sum;
	logic [DIST_W-1:0]  dst_new;
	logic [DIST_W:0]    res_diff;
	logic [DIST_W-1:0]  res;

	// Root entries read as zero; the root is never written
	assign tbl_a = anc_root_a_q ? '0 : anc_rd_a_q;
	assign tbl_b = anc_root_b_q ? '0 : anc_rd_b_q;
	assign dep_a = dd_root_a_q ? '0 : dep_rd_a_q;
	assign dep_b = dd_root_b_q ? '0 : dep_rd_b_q;
	assign dst_a = dd_root_a_q ? '0 : dst_rd_a_q;
	assign dst_b = dd_root_b_q ? '0 : dst_rd_b_q;

	assign dd_addr_a = ctl.dd_sel_c ? p_q : ra_q;

	// Index reduction: estimate the quotient, subtract its multiple, fix up once
	assign prod_a = PROD_W'(sa_q) * PROD_W'(RECIP);
	assign prod_b = PROD_W'(sb_q) * PROD_W'(RECIP);
	assign qn_a   = QN_W'(qa_q) * QN_W'(MOD_C);
	assign qn_b   = QN_W'(qb_q) * QN_W'(MOD_C);
	assign dif_a  = QN_W'(sa_q) - qn_a;
	assign dif_b  = QN_W'(sb_q) - qn_b;
	assign ra_d   = (rem_a_q >= MOD_C) ? NODE_W'(rem_a_q - MOD_C) : NODE_W'(rem_a_q);
	assign rb_d   = (rem_b_q >= MOD_C) ? NODE_W'(rem_b_q - MOD_C) : NODE_W'(rem_b_q);

	// New node depth and root distance, both saturating
	assign dep_new = (dep_b == DEPTH_SAT) ? DEPTH_SAT : dep_b + 1'b1;
	assign dst_sum = {1'b0, dst_b} + (DIST_W + 1)'(len_q);
	assign dst_new = dst_sum[DIST_W] ? DIST_SAT : dst_sum[DIST_W-1:0];

	// Ancestor write port
	assign anc_we = ctl.wr_node || ctl.wr_lvl;
	assign wr_lvl = ctl.wr_node ? '0 : LVL_W'(lvl_q + 1'b1);
	assign wr_anc = ctl.wr_node ? rb_q : tbl_a;

	// Path length: clamp negative to zero, saturate the top
	assign res_diff = s_q - t_q;
	always_comb begin
		if (s_q < t_q) res = '0;
		else if (res_diff[DIST_W]) res = DIST_SAT;
		else res = res_diff[DIST_W-1:0];
	end

	// Status
	assign sts.red_last    = (red_cnt_q == RED_FIX);
	assign sts.is_query    = (kind_q == KIND_QUERY);
	assign sts.attach_skip = (ra_q == '0) || (ra_q == rb_q);
	assign sts.single_lvl  = (LOG_LEVELS == 1);
	assign sts.lvl_nx_last = (((LVL_W + 1)'(lvl_q) + 1'b1) == LVL_MAX_X);
	assign sts.lvl_at_top  = (lvl_q == LVL_MAX);
	assign sts.lvl_zero    = (lvl_q == '0);
	assign sts.diff_bit    = diff_q[0];
	assign sts.p_eq_q      = (p_q == q_q);

	// Ancestor memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (anc_we) anc_mem[ra_q][wr_lvl] <= wr_anc;
		anc_rd_a_q   <= anc_mem[p_q][lvl_q];
		anc_rd_b_q   <= anc_mem[q_q][lvl_q];
		anc_root_a_q <= (p_q == '0);
		anc_root_b_q <= (q_q == '0);
	end

	// Depth and distance memories: one write, two registered reads
	always_ff @(posedge clk) begin
		if (ctl.wr_node) begin
			dep_mem[ra_q] <= dep_new;
			dst_mem[ra_q] <= dst_new;
		end
		dep_rd_a_q  <= dep_mem[dd_addr_a];
		dep_rd_b_q  <= dep_mem[rb_q];
		dst_rd_a_q  <= dst_mem[dd_addr_a];
		dst_rd_b_q  <= dst_mem[rb_q];
		dd_root_a_q <= (dd_addr_a == '0);
		dd_root_b_q <= (rb_q == '0);
	end

	// Item capture and index reduction
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			kind_q    <= kind;
			len_q     <= edge_length;
			sa_q      <= node_a;
			sb_q      <= node_b;
			ra_q      <= '0;
			rb_q      <= '0;
			red_cnt_q <= '0;
		end else if (ctl.red_step) begin
			red_cnt_q <= red_cnt_q + 1'b1;
			case (red_cnt_q)
				RED_QUOT: begin
					qa_q <= prod_a[PROD_W-1:32];
					qb_q <= prod_b[PROD_W-1:32];
				end
				RED_REM: begin
					rem_a_q <= dif_a[NODE_W:0];
					rem_b_q <= dif_b[NODE_W:0];
				end
				default: begin
					ra_q <= ra_d;
					rb_q <= rb_d;
				end
			endcase
		end
	end

	// Level counter
	always_ff @(posedge clk) begin
		if (ctl.load || ctl.lvl_clr) lvl_q <= '0;
		else if (ctl.lvl_top) lvl_q <= LVL_MAX;
		else if (ctl.lvl_inc) lvl_q <= lvl_q + 1'b1;
		else if (ctl.lvl_dec) lvl_q <= lvl_q - 1'b1;
	end

	// Walk nodes and depth difference
	always_ff @(posedge clk) begin
		if (ctl.wr_node) begin
			p_q <= rb_q;
		end else if (ctl.swap) begin
			da_q <= dst_a;
			db_q <= dst_b;
			if (dep_a < dep_b) begin
				p_q    <= rb_q;
				q_q    <= ra_q;
				diff_q <= dep_b - dep_a;
			end else begin
				p_q    <= ra_q;
				q_q    <= rb_q;
				diff_q <= dep_a - dep_b;
			end
		end else if (ctl.p_from_tbl) begin
			p_q <= tbl_a;
		end else if (ctl.jump && (tbl_a != tbl_b)) begin
			p_q <= tbl_a;
			q_q <= tbl_b;
		end
		if (ctl.diff_shift) diff_q <= diff_q >> 1;
	end

	// Path length terms and result register
	always_ff @(posedge clk) begin
		if (ctl.sum) begin
			s_q <= {1'b0, da_q} + {1'b0, db_q};
			t_q <= {dst_a, 1'b0};
		end
		if (ctl.out_load) begin
			dist_q <= res;
			ca_q   <= p_q;
		end
	end

	assign distance        = dist_q;
	assign common_ancestor = IN_NODE_W'(ca_q);

endmodule
